[rtl/rsi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_pkg
// Widths and types shared by the ray / sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

	localparam int COORD_WIDTH   = 32;
	localparam int DIR_FRAC_BITS = 14;

	localparam int DIR_WIDTH = DIR_FRAC_BITS + 2;
	localparam int RAD_WIDTH = COORD_WIDTH - 1;
	localparam int P_WIDTH   = COORD_WIDTH + 1;            // origin - centre
	localparam int PD_WIDTH  = P_WIDTH + DIR_WIDTH;        // one p*d term
	localparam int DOT_WIDTH = PD_WIDTH + 2;               // sum of three
	localparam int PP_WIDTH  = 2 * P_WIDTH;                // one p*p term
	localparam int PPS_WIDTH = PP_WIDTH + 2;               // sum of three
	localparam int R2_WIDTH  = 2 * RAD_WIDTH;
	localparam int DIFF_WIDTH = PPS_WIDTH + 1;             // r*r - p.p, signed
	localparam int B_WIDTH   = DOT_WIDTH + 1 - DIR_FRAC_BITS;
	localparam int BLO_WIDTH = B_WIDTH / 2;
	localparam int BHI_WIDTH = B_WIDTH - BLO_WIDTH;
	localparam int BB_WIDTH  = 2 * B_WIDTH;
	localparam int DISC_WIDTH = ((BB_WIDTH > DIFF_WIDTH) ? BB_WIDTH : DIFF_WIDTH) + 2;
	localparam int ROOT_WIDTH = DISC_WIDTH / 2;
	localparam int SQ_WIDTH   = 2 * ROOT_WIDTH + 2;
	localparam int END_WIDTH  = ((B_WIDTH > ROOT_WIDTH) ? B_WIDTH : ROOT_WIDTH) + 2;

	localparam int IN_BITS    = 6 * COORD_WIDTH + 3 * DIR_WIDTH + RAD_WIDTH;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = 1 + RAD_WIDTH;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// first field sits in the low bits, so it is the last member here
	typedef struct packed {
		logic [RAD_WIDTH-1:0]          sphere_radius;
		logic signed [COORD_WIDTH-1:0] center_z;
		logic signed [COORD_WIDTH-1:0] center_y;
		logic signed [COORD_WIDTH-1:0] center_x;
		logic signed [DIR_WIDTH-1:0]   ray_dir_z;
		logic signed [DIR_WIDTH-1:0]   ray_dir_y;
		logic signed [DIR_WIDTH-1:0]   ray_dir_x;
		logic signed [COORD_WIDTH-1:0] ray_origin_z;
		logic signed [COORD_WIDTH-1:0] ray_origin_y;
		logic signed [COORD_WIDTH-1:0] ray_origin_x;
	} rsi_in_t;

	// travels alongside the square root
	typedef struct packed {
		logic                      neg;
		logic signed [B_WIDTH-1:0] b;
	} rsi_side_t;

endpackage
`default_nettype wire

[rtl/rsi_geom.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_geom
// Seven stages: offset, products, sums, b and r*r - p.p, split b*b, b*b, disc.
// ----------------------------------------------------------------------------
module rsi_geom
	import rsi_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire rsi_in_t                      in_item,
	output logic                              out_valid,
	output logic [DISC_WIDTH-2:0]             rad,
	output rsi_side_t                         side
);

	logic [7:1] vld_s;

	logic signed [P_WIDTH-1:0]   p_s1 [3];
	logic signed [DIR_WIDTH-1:0] d_s1 [3];
	logic [RAD_WIDTH-1:0]        r_s1;

	logic signed [PD_WIDTH-1:0]  pd_s2 [3];
	logic signed [PP_WIDTH-1:0]  pp_s2 [3];
	logic [R2_WIDTH-1:0]         r2_s2;

	logic signed [DOT_WIDTH-1:0] dot_s3;
	logic [PPS_WIDTH-1:0]        pps_s3;
	logic [R2_WIDTH-1:0]         r2_s3;

	logic signed [B_WIDTH-1:0]    b_s4;
	logic [B_WIDTH-1:0]           bmag_s4;
	logic signed [DIFF_WIDTH-1:0] diff_s4;

	logic signed [B_WIDTH-1:0]    b_s5;
	logic signed [DIFF_WIDTH-1:0] diff_s5;
	logic [2*BHI_WIDTH-1:0]       hh_s5;
	logic [BHI_WIDTH+BLO_WIDTH-1:0] hl_s5;
	logic [2*BLO_WIDTH-1:0]       ll_s5;

	logic signed [B_WIDTH-1:0]    b_s6;
	logic signed [DIFF_WIDTH-1:0] diff_s6;
	logic [BB_WIDTH-1:0]          bb_s6;

	logic signed [B_WIDTH-1:0]    b_s7;
	logic signed [DISC_WIDTH-1:0] disc_s7;

	logic signed [COORD_WIDTH-1:0] org [3];
	logic signed [COORD_WIDTH-1:0] ctr [3];
	logic signed [DIR_WIDTH-1:0]   dir [3];
	logic signed [DOT_WIDTH:0]     negdot;
	logic [B_WIDTH-1:0]            bmag;

	assign org[0] = in_item.ray_origin_x;
	assign org[1] = in_item.ray_origin_y;
	assign org[2] = in_item.ray_origin_z;
	assign ctr[0] = in_item.center_x;
	assign ctr[1] = in_item.center_y;
	assign ctr[2] = in_item.center_z;
	assign dir[0] = in_item.ray_dir_x;
	assign dir[1] = in_item.ray_dir_y;
	assign dir[2] = in_item.ray_dir_z;

	// b = floor(-dot / 2^frac)
	assign negdot = -{dot_s3[DOT_WIDTH-1], dot_s3};
	assign bmag   = negdot[DOT_WIDTH] ? B_WIDTH'(-negdot[DOT_WIDTH:DIR_FRAC_BITS])
	                                  : negdot[DOT_WIDTH:DIR_FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[6:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i]  <= P_WIDTH'(org[i]) - P_WIDTH'(ctr[i]);
				d_s1[i]  <= dir[i];
				pd_s2[i] <= PD_WIDTH'(p_s1[i] * d_s1[i]);
				pp_s2[i] <= PP_WIDTH'(p_s1[i] * p_s1[i]);
			end
			r_s1  <= in_item.sphere_radius;
			r2_s2 <= R2_WIDTH'(r_s1 * r_s1);

			dot_s3 <= DOT_WIDTH'(pd_s2[0]) + DOT_WIDTH'(pd_s2[1]) + DOT_WIDTH'(pd_s2[2]);
			pps_s3 <= PPS_WIDTH'(unsigned'(pp_s2[0])) + PPS_WIDTH'(unsigned'(pp_s2[1]))
			        + PPS_WIDTH'(unsigned'(pp_s2[2]));
			r2_s3  <= r2_s2;

			b_s4    <= negdot[DOT_WIDTH:DIR_FRAC_BITS];
			bmag_s4 <= bmag;
			diff_s4 <= DIFF_WIDTH'(r2_s3) - DIFF_WIDTH'(pps_s3);

			// |b|^2 from three narrower products
			hh_s5   <= bmag_s4[B_WIDTH-1:BLO_WIDTH] * bmag_s4[B_WIDTH-1:BLO_WIDTH];
			hl_s5   <= bmag_s4[B_WIDTH-1:BLO_WIDTH] * bmag_s4[BLO_WIDTH-1:0];
			ll_s5   <= bmag_s4[BLO_WIDTH-1:0] * bmag_s4[BLO_WIDTH-1:0];
			b_s5    <= b_s4;
			diff_s5 <= diff_s4;

			bb_s6   <= (BB_WIDTH'(hh_s5) << (2 * BLO_WIDTH))
			         + (BB_WIDTH'(hl_s5) << (BLO_WIDTH + 1)) + BB_WIDTH'(ll_s5);
			b_s6    <= b_s5;
			diff_s6 <= diff_s5;

			disc_s7 <= DISC_WIDTH'(bb_s6) + DISC_WIDTH'(diff_s6);
			b_s7    <= b_s6;
		end
	end

	assign out_valid = vld_s[7];
	assign rad       = disc_s7[DISC_WIDTH-2:0];
	assign side.neg  = disc_s7[DISC_WIDTH-1];
	assign side.b    = b_s7;

endmodule
`default_nettype wire

[rtl/rsi_sqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined integer square root, rounded down, one root bit per stage.
// ----------------------------------------------------------------------------
module rsi_sqrt
	import rsi_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_valid,
	input  wire logic [DISC_WIDTH-2:0]   rad,
	input  wire rsi_side_t               in_side,
	output logic                         out_valid,
	output logic [ROOT_WIDTH-1:0]        root,
	output rsi_side_t                    out_side
);

	// index 0 is the input, the rest are registers
	logic [SQ_WIDTH-1:0]   rem_s  [ROOT_WIDTH+1];
	logic [ROOT_WIDTH-1:0] root_s [ROOT_WIDTH+1];
	rsi_side_t             side_s [ROOT_WIDTH+1];
	logic [ROOT_WIDTH:0]   vld_s;

	assign rem_s[0]  = SQ_WIDTH'(rad);
	assign root_s[0] = '0;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_valid;

	for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_step
		localparam int BIT = ROOT_WIDTH - 1 - k;
		logic [SQ_WIDTH-1:0] trial;
		logic                take;

		// (root + 2^bit)^2 - root^2
		assign trial = (SQ_WIDTH'(root_s[k]) << (BIT + 1)) | (SQ_WIDTH'(1) << (2 * BIT));
		assign take  = rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? rem_s[k] - trial : rem_s[k];
				root_s[k+1] <= root_s[k] | (take ? ROOT_WIDTH'(1) << BIT : '0);
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[ROOT_WIDTH];
	assign root      = root_s[ROOT_WIDTH];
	assign out_side  = side_s[ROOT_WIDTH];

endmodule
`default_nettype wire

[rtl/ray_sphere_intersection_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ray_sphere_intersection_top
// Geometric ray / sphere test: hit flag and saturated unsigned Q15.16 distance.
// ----------------------------------------------------------------------------
// One ray per clock enters and one result leaves per clock. Each ray passes
// through seven stages of products and sums, one stage per root bit of the
// square root, and the output register. The whole pipeline holds while the
// output item waits, so s_tready follows m_tready whenever a result is on
// the output.
module ray_sphere_intersection_top
	import rsi_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// ray_origin_x/y/z, ray_dir_x/y/z, center_x/y/z, sphere_radius, zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// hit, distance
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	logic                   en;
	rsi_in_t                in_item;
	logic                   geom_valid;
	logic [DISC_WIDTH-2:0]  rad;
	rsi_side_t              geom_side;
	logic                   sq_valid;
	logic [ROOT_WIDTH-1:0]  root;
	rsi_side_t              sq_side;

	logic signed [END_WIDTH-1:0] far_end;
	logic signed [END_WIDTH-1:0] near_end;
	logic                        hit_c;
	logic [RAD_WIDTH-1:0]        dist_c;

	logic                        vld_q;
	logic                        hit_q;
	logic [RAD_WIDTH-1:0]        dist_q;

	assign en       = !vld_q || m_tready;
	assign s_tready = en;
	assign in_item  = s_tdata[IN_BITS-1:0];

	rsi_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_item   (in_item),
		.out_valid (geom_valid),
		.rad       (rad),
		.side      (geom_side)
	);

	rsi_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (geom_valid),
		.rad       (rad),
		.in_side   (geom_side),
		.out_valid (sq_valid),
		.root      (root),
		.out_side  (sq_side)
	);

	assign far_end  = END_WIDTH'(sq_side.b) + END_WIDTH'(root);
	assign near_end = END_WIDTH'(sq_side.b) - END_WIDTH'(root);
	assign hit_c    = !sq_side.neg && !far_end[END_WIDTH-1];

	always_comb begin
		if (!hit_c || near_end[END_WIDTH-1]) begin
			dist_c = '0;
		end else if (|near_end[END_WIDTH-1:RAD_WIDTH]) begin
			dist_c = '1;
		end else begin
			dist_c = near_end[RAD_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q  <= hit_c;
			dist_q <= dist_c;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = OUT_TDATA_W'({dist_q, hit_q});

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !hit_q |-> dist_q == '0)
		else $error("miss item with non-zero distance");

	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(sq_valid) && $stable(root))
		else $error("square root pipeline moved during stall");

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Ray / sphere intersection pipeline testbench.
// ----------------------------------------------------------------------------
// Rays are pushed through the stream input with random gaps and output stalls.
// A predictor works out hit and distance for every accepted item with wide
// signed arithmetic and an integer square root; each result is checked in
// order against the queue of predicted intersections.
module tb_top;
	import rsi_pkg::*;

	// hit sits in bit 0 of m_tdata, so it is the last member here
	typedef struct packed {
		logic [RAD_WIDTH-1:0]      distance;
		logic                      hit;
	} isect_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	isect_t isect_q[$];
	int n_errors = 0;
	bit idle_en = 1'b1;
	bit done = 1'b0;

	always #2 clk = ~clk;

	ray_sphere_intersection_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	function automatic logic [127:0] isqrt(logic [127:0] x);
		logic [127:0] res;
		logic [127:0] cand;
		res = '0;
		for (int i = 63; i >= 0; i--) begin
			cand = res | (128'd1 << i);
			if (cand * cand <= x)
				res = cand;
		end
		return res;
	endfunction

	function automatic isect_t predict_isect(rsi_in_t ray);
		logic signed [127:0] p[3];
		logic signed [127:0] d[3];
		logic signed [127:0] dot, pp, b, r, disc, s, bs;
		isect_t res;
		p[0] = 128'(ray.ray_origin_x) - 128'(ray.center_x);
		p[1] = 128'(ray.ray_origin_y) - 128'(ray.center_y);
		p[2] = 128'(ray.ray_origin_z) - 128'(ray.center_z);
		d[0] = 128'(ray.ray_dir_x);
		d[1] = 128'(ray.ray_dir_y);
		d[2] = 128'(ray.ray_dir_z);
		dot = 0;
		pp = 0;
		for (int i = 0; i < 3; i++) begin
			dot += p[i] * d[i];
			pp += p[i] * p[i];
		end
		r = $signed({97'd0, ray.sphere_radius});
		b = (-dot) >>> DIR_FRAC_BITS;
		disc = b * b - pp + r * r;
		res = '0;
		if (disc < 0)
			return res;
		s = $signed(isqrt(disc));
		if (b + s < 0)
			return res;
		bs = b - s;
		if (bs < 0)
			bs = 0;
		if (bs > (128'sd1 <<< RAD_WIDTH) - 1)
			bs = (128'sd1 <<< RAD_WIDTH) - 1;
		res.hit = 1'b1;
		res.distance = bs[RAD_WIDTH-1:0];
		return res;
	endfunction

	// returns at the falling edge after the item is accepted, valid still high
	task automatic send_ray(rsi_in_t ray);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_tdata <= IN_TDATA_W'(ray);
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		isect_q.push_back(predict_isect(ray));
		@(negedge clk);
	endtask

	// output stalls in bursts
	initial begin
		forever begin
			@(negedge clk);
			if (idle_en && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		isect_t got, want;
		if (m_tvalid && m_tready) begin
			got = isect_t'(m_tdata[OUT_BITS-1:0]);
			if (isect_q.size() == 0) begin
				$error("unexpected result %h", got);
				n_errors++;
			end else begin
				want = isect_q.pop_front();
				if (got.hit !== want.hit) begin
					$error("hit: expected %0d actual %0d", want.hit, got.hit);
					n_errors++;
				end
				if (got.distance !== want.distance) begin
					$error("distance: expected %0d actual %0d", want.distance,
						got.distance);
					n_errors++;
				end
			end
		end
	end

	function automatic rsi_in_t rand_ray(bit wild);
		rsi_in_t ray;
		int sp;
		ray = '0;
		if (wild) begin
			ray.ray_origin_x = $urandom; ray.ray_origin_y = $urandom;
			ray.ray_origin_z = $urandom; ray.center_x = $urandom;
			ray.center_y = $urandom; ray.center_z = $urandom;
			ray.sphere_radius = 31'($urandom);
			ray.ray_dir_x = 16'($signed($urandom_range(0, 32768)) - 16384);
			ray.ray_dir_y = 16'($signed($urandom_range(0, 32768)) - 16384);
			ray.ray_dir_z = 16'($signed($urandom_range(0, 32768)) - 16384);
		end else begin
			// scene near the origin, ray pointed roughly at the sphere
			sp = $urandom_range(8, 24);
			ray.center_x = $signed($urandom) >>> (31 - sp);
			ray.center_y = $signed($urandom) >>> (31 - sp);
			ray.center_z = $signed($urandom) >>> (31 - sp);
			ray.ray_origin_x = $signed($urandom) >>> (31 - sp);
			ray.ray_origin_y = $signed($urandom) >>> (31 - sp);
			ray.ray_origin_z = $signed($urandom) >>> (31 - sp);
			ray.sphere_radius = 31'($urandom >> (32 - sp));
			case ($urandom_range(0, 2))
				0: ray.ray_dir_x = 16'($urandom_range(0, 1) ? 16384 : -16384);
				1: ray.ray_dir_y = 16'($urandom_range(0, 1) ? 16384 : -16384);
				default: begin
					ray.ray_dir_x = 16'sd11585; ray.ray_dir_y = -16'sd11585;
				end
			endcase
		end
		return ray;
	endfunction

	task automatic test_directed();
		rsi_in_t ray;
		// origin at centre: inside, distance zero
		ray = '0; ray.sphere_radius = 31'h10000; ray.ray_dir_x = 16'sd16384;
		send_ray(ray);
		// straight hit ahead at 10 units
		ray.center_x = 32'sh140000; ray.sphere_radius = 31'ha0000;
		send_ray(ray);
		// sphere behind the origin
		ray.ray_dir_x = -16'sd16384; send_ray(ray);
		// clean miss, disc below zero
		ray.ray_dir_x = '0; ray.ray_dir_y = 16'sd16384; ray.sphere_radius = 31'h10000;
		send_ray(ray);
		// tangent
		ray.ray_dir_y = '0; ray.ray_dir_x = 16'sd16384; ray.center_x = 32'sh50000;
		ray.center_y = 32'sh10000; send_ray(ray);
		// zero radius, zero direction
		ray = '0; send_ray(ray);
		ray.center_x = 32'sh7fffffff; ray.ray_origin_x = 32'sh80000000;
		ray.ray_dir_x = 16'sd16384; ray.sphere_radius = 31'h7fffffff; send_ray(ray);
		// extremes everywhere: saturation and large discriminants
		ray.ray_origin_y = 32'sh80000000; ray.ray_origin_z = 32'sh80000000;
		ray.center_y = 32'sh7fffffff; ray.center_z = 32'sh7fffffff;
		ray.ray_dir_y = 16'sd16384; ray.ray_dir_z = 16'sd16384; send_ray(ray);
		ray.ray_dir_x = -16'sd16384; ray.ray_dir_y = -16'sd16384;
		ray.ray_dir_z = -16'sd16384;
		send_ray(ray);
		ray = '1; send_ray(ray);
		ray.sphere_radius = '0; ray.ray_dir_x = 16'sh7fff; send_ray(ray);
		// non-unit direction
		ray = '0; ray.center_z = 32'sh100000; ray.sphere_radius = 31'h20000;
		ray.ray_dir_z = 16'sd8192; send_ray(ray);
	endtask

	task automatic test_random(int n, bit idle);
		idle_en = idle;
		for (int i = 0; i < n; i++)
			send_ray(rand_ray($urandom_range(0, 3) == 0));
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(600, 1'b1);
		test_random(150, 1'b0);
		s_tvalid <= 1'b0;
		while (isect_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (n_errors == 0 && isect_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#400000;
		$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
rtl/rsi_pkg.sv
rtl/rsi_geom.sv
rtl/rsi_sqrt.sv
rtl/ray_sphere_intersection_top.sv
tb/sv/tb_top.sv
